// File: hdl/rcf_pkg.sv
// Shared constants, types and register indexes of the RGB 3x3 convolution filter.
package rcf_pkg;

  // Geometry and number formats.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COEF_BITS  = 16;
  localparam int FRAC_BITS  = 8;
  localparam int SLOT_BITS  = 16;
  localparam int TAPS       = 3;
  localparam int NUM_TAPS   = TAPS * TAPS;
  localparam int NUM_LANES  = 3;
  localparam int CHAN_BITS  = 8;
  localparam int PIX_BITS   = NUM_LANES * CHAN_BITS;

  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
  localparam int WIDTH_BITS  = 12;
  localparam int HEIGHT_BITS = 13;
  localparam int KERNEL_BITS = TAPS * SLOT_BITS;

  // Product of an unsigned pixel (with a zero sign bit) and a signed coefficient.
  localparam int PROD_BITS = COEF_BITS + CHAN_BITS + 1;
  // Nine products need four more bits.
  localparam int SUM_BITS  = PROD_BITS + 4;

  // Pipeline and output queue.
  localparam int PIPE_DEPTH     = 5;
  localparam int FIFO_DEPTH     = 8;
  localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);
  localparam int CREDIT_BITS    = $clog2(PIPE_DEPTH + FIFO_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd4;

  // Register reset values.
  localparam logic [WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam logic [KERNEL_BITS-1:0] KERNEL_MID_RESET   = 48'h0000_0100_0000;

  // Lane order inside a packed pixel: red in the low byte.
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;

  typedef logic [CHAN_BITS-1:0] chan_t;
  typedef chan_t [NUM_TAPS-1:0] tap_pix_t;
  typedef logic [COEF_BITS-1:0] coef_t;
  typedef coef_t [NUM_TAPS-1:0] tap_coef_t;
  typedef chan_t [NUM_LANES-1:0] lane_res_t;

  // Position flags carried along the pipeline.
  typedef struct packed {
    logic has_res;
    logic row_end;
    logic frame_end;
  } rcf_flags_t;

  // End markers handed to the output stage.
  typedef struct packed {
    logic row_end;
    logic frame_end;
  } rcf_ends_t;

  // One result beat.
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  row_end;
    logic  frame_end;
  } rcf_beat_t;

endpackage

// File: hdl/rcf_line_buf.sv
// Line store RAM holding the two previous rows, one entry per column.
module rcf_line_buf (
  input  logic                                 clk_i,
  input  logic                                 rd_en_i,
  input  logic [rcf_pkg::COL_BITS-1:0]         rd_addr_i,
  output logic [2*rcf_pkg::PIX_BITS-1:0]       rd_data_o,
  input  logic                                 wr_en_i,
  input  logic [rcf_pkg::COL_BITS-1:0]         wr_addr_i,
  input  logic [2*rcf_pkg::PIX_BITS-1:0]       wr_data_i
);
  import rcf_pkg::*;

  // Each entry holds the upper row pixel in the high half, the lower row pixel in the low half.
  logic [2*PIX_BITS-1:0] mem_q [MAX_WIDTH];
  logic [2*PIX_BITS-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/rcf_lane.sv
// One channel lane: nine multiplies, a two-level adder tree, truncation and clamp.
module rcf_lane (
  input  logic                 clk_i,
  input  rcf_pkg::tap_pix_t    pix_i,
  input  rcf_pkg::tap_coef_t   coef_i,
  output rcf_pkg::chan_t       result_o
);
  import rcf_pkg::*;

  logic signed [PROD_BITS-1:0] prod_q [NUM_TAPS];
  logic signed [SUM_BITS-1:0]  psum_d [TAPS];
  logic signed [SUM_BITS-1:0]  psum_q [TAPS];
  logic signed [SUM_BITS-1:0]  acc_d;
  chan_t                       result_d;
  chan_t                       result_q;

  // Stage one: one product per tap.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_TAPS; i++) begin
      prod_q[i] <= $signed({1'b0, pix_i[i]}) * $signed(coef_i[i]);
    end
  end

  // Stage two: sum each kernel row.
  always_comb begin
    for (int r = 0; r < TAPS; r++) begin
      psum_d[r] = SUM_BITS'(prod_q[TAPS*r]) + SUM_BITS'(prod_q[TAPS*r+1])
                + SUM_BITS'(prod_q[TAPS*r+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < TAPS; r++) begin
      psum_q[r] <= psum_d[r];
    end
  end

  // Stage three: total, drop the fraction and clamp to the pixel range.
  always_comb begin
    acc_d = psum_q[0] + psum_q[1] + psum_q[2];
    if (acc_d <= 0) begin
      result_d = '0;
    end else if (acc_d[SUM_BITS-1:FRAC_BITS+CHAN_BITS] != '0) begin
      result_d = '1;
    end else begin
      result_d = acc_d[FRAC_BITS +: CHAN_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o = result_q;

endmodule

// File: hdl/rcf_merge.sv
// Output stage: merges the three lane results with the end markers and queues the beats.
module rcf_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  rcf_pkg::lane_res_t                lane_res_i,
  input  rcf_pkg::rcf_ends_t                ends_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [7:0]                        out_red_o,
  output logic [7:0]                        out_green_o,
  output logic [7:0]                        out_blue_o,
  output logic                              row_end_o,
  output logic                              frame_end_o,
  output logic [rcf_pkg::FIFO_CNT_BITS-1:0] count_o
);
  import rcf_pkg::*;

  rcf_beat_t                fifo_q [FIFO_DEPTH];
  rcf_beat_t                beat_d;
  rcf_beat_t                head;
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
  logic [FIFO_CNT_BITS-1:0] count_q;
  logic                     pop;

  // Combine the lanes into one beat.
  always_comb begin
    beat_d.red       = lane_res_i[LANE_RED];
    beat_d.green     = lane_res_i[LANE_GREEN];
    beat_d.blue      = lane_res_i[LANE_BLUE];
    beat_d.row_end   = ends_i.row_end;
    beat_d.frame_end = ends_i.frame_end;
  end

  assign pop = out_valid_o && out_ready_i;

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= beat_d;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Head of the queue drives the result channel.
  assign head        = fifo_q[rd_ptr_q];
  assign out_valid_o = (count_q != '0);
  assign out_red_o   = head.red;
  assign out_green_o = head.green;
  assign out_blue_o  = head.blue;
  assign row_end_o   = head.row_end;
  assign frame_end_o = head.frame_end;
  assign count_o     = count_q;

`ifndef SYNTHESIS
  // The input credit check must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < FIFO_CNT_BITS'(FIFO_DEPTH)))
    else $error("result queue written while full");

  // A beat in and a beat out in the same cycle leave the fill level alone.
  a_count_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && pop) |=> $stable(count_q))
    else $error("result queue level moved on a simultaneous push and pop");
`endif

endmodule

// File: hdl/rgb_conv3x3_filter.sv
// RGB 3x3 convolution filter, top level. Pixels enter in raster order at up to one per
// clock cycle, sustained: a pixel is accepted in every cycle while the pipeline and the
// result queue together hold fewer items than the queue depth. A result passes through
// the line store read, the window shift, the product, row-sum and result registers of
// the multiply-add lanes and the output queue. Three channel lanes apply the same nine
// signed Q8.8 coefficients in parallel; each drops the fraction toward zero and clamps
// to 0..255. Border positions give no beat, so a W x H frame yields (W-2) x (H-2) beats
// with row_end_o and frame_end_o marking row and frame ends. The line stores are not
// cleared after reset; the first two rows of each frame fill them before any result
// depends on them. Configuration must be written only while the filter is idle; writing
// the frame width or height restarts the frame; kernel writes also reach pixels in flight.
module rgb_conv3x3_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rcf_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [rcf_pkg::KERNEL_BITS-1:0]     cfg_data_i,
  // Pixel input channel.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          in_red_i,
  input  logic [7:0]                          in_green_i,
  input  logic [7:0]                          in_blue_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [7:0]                          out_red_o,
  output logic [7:0]                          out_green_o,
  output logic [7:0]                          out_blue_o,
  output logic                                row_end_o,
  output logic                                frame_end_o
);
  import rcf_pkg::*;

  // Configuration registers.
  logic [WIDTH_BITS-1:0]  width_q;
  logic [HEIGHT_BITS-1:0] height_q;
  logic [KERNEL_BITS-1:0] kernel_q [TAPS];

  // Raster position.
  logic [COL_BITS-1:0] column_q;
  logic [ROW_BITS-1:0] row_q;
  logic [COL_BITS-1:0] col_last;
  logic [ROW_BITS-1:0] row_last;

  // Pipeline control and payload.
  logic [PIPE_DEPTH-1:0]     pipe_v_q;
  rcf_flags_t                pipe_f_q [PIPE_DEPTH];
  rcf_flags_t                flags_d;
  logic [PIX_BITS-1:0]       pix1_q;
  logic [COL_BITS-1:0]       col1_q;
  logic [PIX_BITS-1:0]       window_q [TAPS][TAPS];
  logic [2*PIX_BITS-1:0]     lb_rd_data;
  logic [2*PIX_BITS-1:0]     lb_wr_data;

  // Lane operands and results.
  tap_pix_t                  lane_pix [NUM_LANES];
  tap_coef_t                 tap_coef;
  lane_res_t                 lane_res;
  rcf_ends_t                 ends;

  // Flow control.
  logic                      in_accept;
  logic                      cfg_accept;
  logic                      geom_write;
  logic [FIFO_CNT_BITS-1:0]  fifo_count;
  logic [CREDIT_BITS-1:0]    credits_used;

  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign geom_write  = cfg_accept &&
                       (cfg_index_i == REG_FRAME_WIDTH || cfg_index_i == REG_FRAME_HEIGHT);

  // Every item in flight may still need a queue slot.
  assign credits_used = CREDIT_BITS'($countones(pipe_v_q)) + CREDIT_BITS'(fifo_count);
  assign in_ready_o   = (credits_used < CREDIT_BITS'(FIFO_DEPTH));
  assign in_accept    = in_valid_i && in_ready_o;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= FRAME_WIDTH_RESET;
      height_q    <= FRAME_HEIGHT_RESET;
      kernel_q[0] <= '0;
      kernel_q[1] <= KERNEL_MID_RESET;
      kernel_q[2] <= '0;
    end else if (cfg_accept) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:   width_q     <= cfg_data_i[WIDTH_BITS-1:0];
        REG_FRAME_HEIGHT:  height_q    <= cfg_data_i[HEIGHT_BITS-1:0];
        REG_KERNEL_TOP:    kernel_q[0] <= cfg_data_i;
        REG_KERNEL_MIDDLE: kernel_q[1] <= cfg_data_i;
        REG_KERNEL_BOTTOM: kernel_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Last column and row, with the geometry clamped to its legal range.
  always_comb begin
    if (width_q < WIDTH_BITS'(TAPS)) begin
      col_last = COL_BITS'(TAPS - 1);
    end else if (width_q > WIDTH_BITS'(MAX_WIDTH)) begin
      col_last = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      col_last = COL_BITS'(width_q - 1'b1);
    end
    if (height_q < HEIGHT_BITS'(TAPS)) begin
      row_last = ROW_BITS'(TAPS - 1);
    end else if (height_q > HEIGHT_BITS'(MAX_HEIGHT)) begin
      row_last = ROW_BITS'(MAX_HEIGHT - 1);
    end else begin
      row_last = ROW_BITS'(height_q - 1'b1);
    end
  end

  // Position flags of the pixel being accepted.
  always_comb begin
    flags_d.has_res   = (column_q >= COL_BITS'(TAPS - 1)) && (row_q >= ROW_BITS'(TAPS - 1));
    flags_d.row_end   = (column_q == col_last);
    flags_d.frame_end = (column_q == col_last) && (row_q == row_last);
  end

  // Raster counters; a geometry write restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
    end else if (geom_write) begin
      column_q <= '0;
      row_q    <= '0;
    end else if (in_accept) begin
      if (column_q == col_last) begin
        column_q <= '0;
        row_q    <= (row_q == row_last) ? '0 : row_q + 1'b1;
      end else begin
        column_q <= column_q + 1'b1;
      end
    end
  end

  // Valid bits of the pipeline stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_v_q <= '0;
    end else begin
      pipe_v_q <= {pipe_v_q[PIPE_DEPTH-2:0], in_accept};
    end
  end

  // Flags and pixel payload follow the valid bits.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pipe_f_q[0] <= flags_d;
      pix1_q      <= {in_blue_i, in_green_i, in_red_i};
      col1_q      <= column_q;
    end
    for (int s = 1; s < PIPE_DEPTH; s++) begin
      pipe_f_q[s] <= pipe_f_q[s-1];
    end
  end

  // Line stores: read the column on accept, write it back in the cycle after.
  assign lb_wr_data = {lb_rd_data[PIX_BITS-1:0], pix1_q};

  rcf_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (column_q),
    .rd_data_o (lb_rd_data),
    .wr_en_i   (pipe_v_q[0]),
    .wr_addr_i (col1_q),
    .wr_data_i (lb_wr_data)
  );

  // The 3x3 window shifts left and takes the new column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < TAPS; r++) begin
        for (int c = 0; c < TAPS; c++) begin
          window_q[r][c] <= '0;
        end
      end
    end else if (pipe_v_q[0]) begin
      for (int r = 0; r < TAPS; r++) begin
        window_q[r][0] <= window_q[r][1];
        window_q[r][1] <= window_q[r][2];
      end
      window_q[0][2] <= lb_rd_data[2*PIX_BITS-1:PIX_BITS];
      window_q[1][2] <= lb_rd_data[PIX_BITS-1:0];
      window_q[2][2] <= pix1_q;
    end
  end

  // Spread the window and kernel over the lanes.
  always_comb begin
    for (int r = 0; r < TAPS; r++) begin
      for (int c = 0; c < TAPS; c++) begin
        tap_coef[TAPS*r+c] = kernel_q[r][SLOT_BITS*c +: COEF_BITS];
        for (int l = 0; l < NUM_LANES; l++) begin
          lane_pix[l][TAPS*r+c] = window_q[r][c][CHAN_BITS*l +: CHAN_BITS];
        end
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    rcf_lane u_lane (
      .clk_i    (clk_i),
      .pix_i    (lane_pix[l]),
      .coef_i   (tap_coef),
      .result_o (lane_res[l])
    );
  end

  assign ends.row_end   = pipe_f_q[PIPE_DEPTH-1].row_end;
  assign ends.frame_end = pipe_f_q[PIPE_DEPTH-1].frame_end;

  rcf_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pipe_v_q[PIPE_DEPTH-1] && pipe_f_q[PIPE_DEPTH-1].has_res),
    .lane_res_i  (lane_res),
    .ends_i      (ends),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o),
    .count_o     (fifo_count)
  );

`ifndef SYNTHESIS
  // A geometry write restarts the raster position.
  a_geom_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    geom_write |=> (column_q == '0 && row_q == '0))
    else $error("frame position not cleared after a geometry write");

  // An accepted pixel always lies inside the current row.
  a_column_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (column_q <= col_last))
    else $error("column counter beyond the last column");
`endif

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the RGB 3x3 convolution filter.
`timescale 1ns / 1ps

module testbench;
  import rcf_pkg::*;

  // Settle time that covers the top level's pixel-to-result path with room to spare.
  localparam int SETTLE_CYCLES = 2 * (PIPE_DEPTH + 1);
  localparam int DRAIN_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_PERCENT  = 30;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_PIXELS = 850;
  localparam int STRESS_WIDTH  = 64;
  localparam int STRESS_HEIGHT = 6;
  localparam int NARROW_ROWS   = 100;
  localparam int NO_EVENT      = -1;
  localparam longint LEVEL_MAX = (1 << CHAN_BITS) - 1;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [KERNEL_BITS-1:0]  cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [7:0]              in_red_i;
  logic [7:0]              in_green_i;
  logic [7:0]              in_blue_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [7:0]              out_red_o;
  logic [7:0]              out_green_o;
  logic [7:0]              out_blue_o;
  logic                    row_end_o;
  logic                    frame_end_o;

  // Shared flags between the pixel source and the result sink.
  bit no_idle;
  bit hold_request;

  rgb_conv3x3_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

  // Filter predictor and queue of filtered pixels still owed by the block.
  class filter_scoreboard;
    logic [PIX_BITS-1:0]    upper_row [MAX_WIDTH];
    logic [PIX_BITS-1:0]    lower_row [MAX_WIDTH];
    logic [PIX_BITS-1:0]    window [TAPS][TAPS];
    logic [KERNEL_BITS-1:0] kernel [TAPS];
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    int unsigned            col;
    int unsigned            row;
    rcf_beat_t              expected_beats [$];
    int                     failures;

    function new();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      for (int r = 0; r < TAPS; r++) begin
        for (int c = 0; c < TAPS; c++) begin
          window[r][c] = '0;
        end
      end
      kernel[0]  = '0;
      kernel[1]  = KERNEL_MID_RESET;
      kernel[2]  = '0;
      width_reg  = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      col        = 0;
      row        = 0;
      failures   = 0;
    endfunction

    // Geometry as the block uses it: clamped to the supported range.
    function int unsigned cols();
      int unsigned w;
      w = width_reg;
      if (w < TAPS) w = TAPS;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
    endfunction

    function int unsigned rows();
      int unsigned h;
      h = height_reg;
      if (h < TAPS) h = TAPS;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function string show(rcf_beat_t b);
      return $sformatf("rgb=%02h/%02h/%02h row_end=%b frame_end=%b",
                       b.red, b.green, b.blue, b.row_end, b.frame_end);
    endfunction

    function void note_failure(string msg);
      if (failures < MAX_REPORTS) begin
        $display("[%0t] %s", $time, msg);
      end
      failures++;
    endfunction

    // One channel: signed Q8.8 sum, fraction dropped toward zero, clamped to 0..255.
    function chan_t lane_result(int lane);
      longint  acc;
      shortint coef;
      int      level;
      acc = 0;
      for (int r = 0; r < TAPS; r++) begin
        for (int c = 0; c < TAPS; c++) begin
          coef  = kernel[r][c*SLOT_BITS +: SLOT_BITS];
          level = int'(window[r][c][lane*CHAN_BITS +: CHAN_BITS]);
          acc  += longint'(coef) * longint'(level);
        end
      end
      if (acc <= 0) return '0;
      acc = acc >>> FRAC_BITS;
      return (acc > LEVEL_MAX) ? chan_t'(LEVEL_MAX) : chan_t'(acc);
    endfunction

    function void note_config(logic [CFG_IDX_BITS-1:0] idx, logic [KERNEL_BITS-1:0] data);
      case (idx)
        REG_FRAME_WIDTH: begin
          width_reg = data[WIDTH_BITS-1:0];
          col = 0;
          row = 0;
        end
        REG_FRAME_HEIGHT: begin
          height_reg = data[HEIGHT_BITS-1:0];
          col = 0;
          row = 0;
        end
        REG_KERNEL_TOP:    kernel[0] = data;
        REG_KERNEL_MIDDLE: kernel[1] = data;
        REG_KERNEL_BOTTOM: kernel[2] = data;
        default: ;
      endcase
    endfunction

    // Advance line stores and window by one pixel; interior positions owe a beat.
    function void note_pixel(chan_t red, chan_t green, chan_t blue);
      int unsigned         x;
      int unsigned         y;
      int unsigned         w;
      int unsigned         h;
      logic [PIX_BITS-1:0] pix;
      logic [PIX_BITS-1:0] two_up;
      logic [PIX_BITS-1:0] one_up;
      rcf_beat_t           beat;
      w = cols();
      h = rows();
      x = (col >= w) ? w - 1 : col;
      y = (row >= h) ? h - 1 : row;
      pix    = {blue, green, red};
      two_up = upper_row[x];
      one_up = lower_row[x];
      upper_row[x] = one_up;
      lower_row[x] = pix;
      for (int r = 0; r < TAPS; r++) begin
        window[r][0] = window[r][1];
        window[r][1] = window[r][2];
      end
      window[0][2] = two_up;
      window[1][2] = one_up;
      window[2][2] = pix;
      if (x >= TAPS - 1 && y >= TAPS - 1) begin
        beat.red       = lane_result(LANE_RED);
        beat.green     = lane_result(LANE_GREEN);
        beat.blue      = lane_result(LANE_BLUE);
        beat.row_end   = (x == w - 1);
        beat.frame_end = (x == w - 1) && (y == h - 1);
        expected_beats.push_back(beat);
      end
      if (x + 1 >= w) begin
        col = 0;
        row = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        col = x + 1;
        row = y;
      end
    endfunction

    function void check_beat(rcf_beat_t got);
      rcf_beat_t want;
      if (expected_beats.size() == 0) begin
        note_failure($sformatf("unexpected result beat %s", show(got)));
        return;
      end
      want = expected_beats.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.row_end !== want.row_end || got.frame_end !== want.frame_end) begin
        note_failure($sformatf("result mismatch: expected %s, got %s",
                               show(want), show(got)));
      end
    endfunction

    // Beats that never came count as failures.
    function void flush_leftovers();
      if (expected_beats.size() != 0) begin
        note_failure($sformatf("%0d result beats never arrived, first expected %s",
                               expected_beats.size(), show(expected_beats[0])));
        failures += expected_beats.size() - 1;
        expected_beats.delete();
      end
    endfunction
  endclass

  filter_scoreboard sb;
  rcf_beat_t        seen_beat;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run.
  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  // Result sink: random back-pressure, plus a long hold-off when asked for.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Result monitor: every accepted beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      seen_beat.red       = out_red_o;
      seen_beat.green     = out_green_o;
      seen_beat.blue      = out_blue_o;
      seen_beat.row_end   = row_end_o;
      seen_beat.frame_end = frame_end_o;
      sb.check_beat(seen_beat);
    end
  end

  function automatic chan_t rand_level();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return chan_t'($urandom);
  endfunction

  // Mostly small coefficients so sums land mid-range; some fully random slots.
  function automatic logic [KERNEL_BITS-1:0] rand_kernel_row();
    logic [KERNEL_BITS-1:0] v;
    for (int c = 0; c < TAPS; c++) begin
      if ($urandom_range(99) < 20) begin
        v[c*SLOT_BITS +: SLOT_BITS] = SLOT_BITS'($urandom);
      end else begin
        v[c*SLOT_BITS +: SLOT_BITS] = SLOT_BITS'($urandom_range(176) - 48);
      end
    end
    return v;
  endfunction

  // Random source gaps, each one a full cycle with valid low.
  task automatic sender_gap();
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  // Offer one pixel beat and hold it until accepted; valid stays high afterwards.
  task automatic send_pixel(input chan_t red, input chan_t green, input chan_t blue);
    sender_gap();
    in_valid_i <= 1'b1;
    in_red_i   <= red;
    in_green_i <= green;
    in_blue_i  <= blue;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.note_pixel(red, green, blue);
  endtask

  task automatic send_pixels(input int count, input int hold_at, input int pause_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_request = 1'b1;
      if (i == pause_at) begin
        // Stop offering pixels until every owed beat has come out.
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
      end
      send_pixel(rand_level(), rand_level(), rand_level());
    end
  endtask

  // Bring the block to rest: no pixels offered, nothing owed, pipeline empty.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [KERNEL_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.note_config(idx, data);
  endtask

  task automatic end_writes();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Geometry writes carry random junk above the register width.
  task automatic write_geometry(input int unsigned w, input int unsigned h);
    logic [KERNEL_BITS-1:0] data;
    data = KERNEL_BITS'({$urandom, $urandom});
    data[WIDTH_BITS-1:0] = WIDTH_BITS'(w);
    write_reg(REG_FRAME_WIDTH, data);
    data = KERNEL_BITS'({$urandom, $urandom});
    data[HEIGHT_BITS-1:0] = HEIGHT_BITS'(h);
    write_reg(REG_FRAME_HEIGHT, data);
  endtask

  task automatic write_kernel(input logic [KERNEL_BITS-1:0] top_row,
                              input logic [KERNEL_BITS-1:0] mid_row,
                              input logic [KERNEL_BITS-1:0] bot_row);
    write_reg(REG_KERNEL_TOP, top_row);
    write_reg(REG_KERNEL_MIDDLE, mid_row);
    write_reg(REG_KERNEL_BOTTOM, bot_row);
  endtask

  // Stimulus.
  initial begin
    int unsigned random_items;
    int unsigned frame_no;
    int unsigned full;
    int unsigned count;
    int unsigned split;
    int unsigned w;
    int unsigned h;
    int unsigned roll;
    int          waited;
    sb = new();
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_red_i    <= '0;
    in_green_i  <= '0;
    in_blue_i   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest frame, out-of-range geometry clamped up, writes to unused indexes.
    write_geometry(0, 2);
    for (int i = REG_KERNEL_BOTTOM + 1; i < 2 ** CFG_IDX_BITS; i++) begin
      write_reg(CFG_IDX_BITS'(i), KERNEL_BITS'({$urandom, $urandom}));
    end
    end_writes();
    // Reset kernel passes the centre pixel; the rest sit at 0 or 255 per channel.
    for (int i = 0; i < NUM_TAPS; i++) begin
      if (i == NUM_TAPS / 2) begin
        send_pixel(8'hFF, 8'h00, 8'h80);
      end else begin
        send_pixel(chan_t'(-$urandom_range(1)), chan_t'(-$urandom_range(1)),
                   chan_t'(-$urandom_range(1)));
      end
    end

    // Most positive coefficients on full-scale pixels saturate high.
    quiesce();
    write_geometry(TAPS, TAPS + 1);
    write_kernel(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
    end_writes();
    repeat (NUM_TAPS) send_pixel('1, '1, '1);
    // Most negative coefficients mid-frame clamp to zero.
    quiesce();
    write_kernel(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
    end_writes();
    repeat (TAPS) send_pixel('1, '1, '1);

    // A full wide frame; the sink holds off mid-frame, later the source pauses.
    quiesce();
    write_geometry(STRESS_WIDTH, STRESS_HEIGHT);
    write_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
    end_writes();
    send_pixels(STRESS_WIDTH * STRESS_HEIGHT, 2 * STRESS_WIDTH + 10, 4 * STRESS_WIDTH + 20);

    // Width clamped up to three and height clamped down, with no random idling; the sink still holds off once.
    quiesce();
    write_geometry(TAPS - 1, (1 << HEIGHT_BITS) - 1);
    end_writes();
    no_idle = 1'b1;
    send_pixels(TAPS * NARROW_ROWS, 40, NO_EVENT);
    no_idle = 1'b0;

    // Random frames, reconfigured between frames and now and then mid-frame.
    random_items = 0;
    frame_no = 0;
    while (random_items < RANDOM_PIXELS) begin
      quiesce();
      if (frame_no == 0 || $urandom_range(99) < 70) begin
        roll = $urandom_range(99);
        if (roll < 10) w = $urandom_range(TAPS - 1);
        else if (roll < 80) w = $urandom_range(12, TAPS);
        else if (roll < 95) w = $urandom_range(64, 13);
        else w = $urandom_range(200, 65);
        if (w > 64) h = $urandom_range(5);
        else if ($urandom_range(99) < 10) h = $urandom_range(TAPS - 1);
        else h = $urandom_range(10, TAPS);
        write_geometry(w, h);
      end
      for (int r = 0; r < TAPS; r++) begin
        if ($urandom_range(99) < 50) write_reg(CFG_IDX_BITS'(REG_KERNEL_TOP + r),
                                               rand_kernel_row());
      end
      if ($urandom_range(99) < 10) begin
        write_reg(CFG_IDX_BITS'($urandom_range(2 ** CFG_IDX_BITS - 1, REG_KERNEL_BOTTOM + 1)),
                  KERNEL_BITS'({$urandom, $urandom}));
      end
      end_writes();
      no_idle = (frame_no >= 8 && frame_no < 12);
      full = sb.cols() * sb.rows();
      roll = $urandom_range(99);
      if (roll < 70) count = full;
      else if (roll < 85) count = $urandom_range(full - 1, 1);
      else count = 2 * full;
      if (count > RANDOM_PIXELS - random_items) count = RANDOM_PIXELS - random_items;
      split = ($urandom_range(99) < 15 && count > 1) ? $urandom_range(count - 1, 1) : count;
      send_pixels(split, (frame_no == 6) ? split / 2 : NO_EVENT,
                  (frame_no == 3) ? split / 2 : NO_EVENT);
      if (split < count) begin
        // Kernel change with the frame half done.
        quiesce();
        write_reg(CFG_IDX_BITS'(REG_KERNEL_TOP + $urandom_range(TAPS - 1)),
                  rand_kernel_row());
        end_writes();
        send_pixels(count - split, NO_EVENT, NO_EVENT);
      end
      random_items += count;
      frame_no++;
    end
    no_idle = 1'b0;

    // Drain, then give stray beats a chance to show up.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.flush_leftovers();
    if (sb.failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/rcf_pkg.sv
hdl/rcf_line_buf.sv
hdl/rcf_lane.sv
hdl/rcf_merge.sv
hdl/rgb_conv3x3_filter.sv
verif/testbench.sv
